@@ rtl/rsqv_pkg.sv @@
// Shared types for the rotated sprite quad vertex block.
// Used by rsqv_front, rsqv_queue, rsqv_back and the top level; no dependencies.
package rsqv_pkg;

  localparam logic REG_COLOR = 1'b0;
  localparam logic REG_TINT  = 1'b1;

  typedef struct packed {
    logic signed [23:0] pivot_x;
    logic signed [23:0] pivot_y;
    logic signed [23:0] corner_x;
    logic signed [23:0] corner_y;
    logic [22:0]        quad_width;
    logic [22:0]        quad_height;
    logic [15:0]        angle;
    logic [15:0]        tex_u_start;
    logic [15:0]        tex_v_start;
    logic [15:0]        tex_u_end;
    logic [15:0]        tex_v_end;
  } sprite_t;

  // one classified sprite, front to back
  typedef struct packed {
    logic signed [23:0] pivot_x;
    logic signed [23:0] pivot_y;
    logic signed [24:0] dx0;
    logic signed [24:0] dy0;
    logic [22:0]        quad_width;
    logic [22:0]        quad_height;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
    logic [15:0]        tex_u_start;
    logic [15:0]        tex_v_start;
    logic [15:0]        tex_u_end;
    logic [15:0]        tex_v_end;
  } qent_t;

  typedef struct packed {
    logic               push;
  } qctl_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               last_vertex;
  } vert_t;

endpackage

@@ rtl/rotated_sprite_quad_vertices.sv @@
// Rotated sprite quad vertex generator, top level.
// Depends on rsqv_pkg, rsqv_front, rsqv_queue and rsqv_back.
//
// Usage:
//   Sprite words arrive on the s_ group, one sprite per accepted word.
//   Each sprite yields four vertex words on the m_ group, in the order
//   lower-left, lower-right, upper-right, upper-left; m_tlast marks the
//   fourth. Colour and tint come from the cfg_ write port (index 0 colour,
//   index 1 tint) and are meant to be written while the block is idle.
//   Throughput: one vertex per cycle while m_tready is high and sprites
//   keep arriving; the single rotate datapath in the back end emits each
//   sprite's four vertices in turn.
//   A four-entry queue separates the front (sine lookup, offsets) from the
//   back (rotation, rounding, saturation); the front keeps accepting until
//   that queue fills.
//   A stall on m_tready freezes the back pipeline and holds the word on m_;
//   the queue then fills and s_tready drops.
//   Reset (rst, synchronous) empties all stages; colour resets to all ones
//   and tint to zero.
module rotated_sprite_quad_vertices #(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pivot_x, pivot_y, corner_x, corner_y, quad_width, quad_height, angle,
  // tex_u_start, tex_v_start, tex_u_end, tex_v_end, zero pad
  input  logic [223:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, vertex_color, vertex_tint, tex_u, tex_v
  output logic [143:0] m_tdata,
  output logic         m_tlast,
  input  logic         cfg_wen,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  rsqv_pkg::sprite_t sprite;
  rsqv_pkg::qctl_t   qctl;
  rsqv_pkg::qent_t   q_wr;
  rsqv_pkg::qent_t   q_rd;
  rsqv_pkg::vert_t   vert;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic [31:0]       color_word;
  logic [31:0]       tint_word;

  assign sprite.pivot_x     = s_tdata[23:0];
  assign sprite.pivot_y     = s_tdata[47:24];
  assign sprite.corner_x    = s_tdata[71:48];
  assign sprite.corner_y    = s_tdata[95:72];
  assign sprite.quad_width  = s_tdata[118:96];
  assign sprite.quad_height = s_tdata[141:119];
  assign sprite.angle       = s_tdata[157:142];
  assign sprite.tex_u_start = s_tdata[173:158];
  assign sprite.tex_v_start = s_tdata[189:174];
  assign sprite.tex_u_end   = s_tdata[205:190];
  assign sprite.tex_v_end   = s_tdata[221:206];

  always_ff @(posedge clk) begin
    if (rst) begin
      color_word <= 32'hFFFF_FFFF;
      tint_word  <= 32'h0000_0000;
    end else if (cfg_wen) begin
      case (cfg_index)
        rsqv_pkg::REG_COLOR: color_word <= cfg_data;
        rsqv_pkg::REG_TINT:  tint_word  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rsqv_front #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_sprite(sprite),
    .qctl     (qctl),
    .q_full   (q_full),
    .qent     (q_wr)
  );

  rsqv_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .qctl   (qctl),
    .wr_data(q_wr),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_data(q_rd)
  );

  rsqv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rd),
    .q_pop    (q_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .vert     (vert)
  );

  assign m_tdata = {vert.tex_v, vert.tex_u, tint_word, color_word, vert.pos_y, vert.pos_x};
  assign m_tlast = vert.last_vertex;

endmodule

@@ rtl/rsqv_sine_rom.sv @@
// Q1.14 sine table, one entry per 1/SINE_TABLE_ENTRIES turn, two registered read ports.
// Contents are built at elaboration; no package dependency.
module rsqv_sine_rom #(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [$clog2(SINE_TABLE_ENTRIES)-1:0] sin_addr,
  input  logic [$clog2(SINE_TABLE_ENTRIES)-1:0] cos_addr,
  output logic signed [15:0]                    sin_q,
  output logic signed [15:0]                    cos_q
);

  localparam longint HALF_PI_Q28 = 64'sd421657428;

  // two truncating multiplies by x in Q4.28
  function automatic longint sq_step(input longint t, input longint x);
    longint p;
    p = (t * x) >>> 28;
    return (p * x) >>> 28;
  endfunction

  // sin(m/N * pi/2), Taylor series in Q4.28
  function automatic longint quarter_sine(input longint m);
    longint x;
    longint term;
    longint sum;
    x    = (m * HALF_PI_Q28) / SINE_TABLE_ENTRIES;
    sum  = x;
    term = sq_step(x, x) / 6;
    sum  = sum - term;
    term = sq_step(term, x) / 20;
    sum  = sum + term;
    term = sq_step(term, x) / 42;
    sum  = sum - term;
    term = sq_step(term, x) / 72;
    sum  = sum + term;
    term = sq_step(term, x) / 110;
    sum  = sum - term;
    term = sq_step(term, x) / 156;
    sum  = sum + term;
    term = sq_step(term, x) / 210;
    sum  = sum - term;
    if (sum < 0) begin
      sum = 0;
    end
    return sum;
  endfunction

  function automatic logic signed [15:0] sine_entry(input int k);
    longint q;
    longint r;
    longint m;
    longint v;
    q = (4 * longint'(k)) / SINE_TABLE_ENTRIES;
    r = 4 * longint'(k) - q * SINE_TABLE_ENTRIES;
    m = q[0] ? (SINE_TABLE_ENTRIES - r) : r;
    v = (quarter_sine(m) + 8192) >>> 14;
    if (q[1]) begin
      v = -v;
    end
    return v[15:0];
  endfunction

  logic signed [15:0] tab [SINE_TABLE_ENTRIES];

  for (genvar k = 0; k < SINE_TABLE_ENTRIES; k++) begin : g_tab
    assign tab[k] = sine_entry(k);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= tab[sin_addr];
      cos_q <= tab[cos_addr];
    end
  end

endmodule

@@ rtl/rsqv_front.sv @@
// Front end: takes sprite words, looks up sine and cosine, forms corner offsets.
// Depends on rsqv_pkg and rsqv_sine_rom.
module rsqv_front #(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rsqv_pkg::sprite_t in_sprite,
  output rsqv_pkg::qctl_t   qctl,
  input  logic            q_full,
  output rsqv_pkg::qent_t   qent
);

  localparam int AW = $clog2(SINE_TABLE_ENTRIES);
  localparam int PW = 16 + AW;

  logic              f1_valid;
  rsqv_pkg::sprite_t f1;
  logic [AW-1:0]     f1_sin_addr;
  logic [AW-1:0]     f1_cos_addr;
  logic              f2_valid;
  logic signed [23:0] f2_pivot_x;
  logic signed [23:0] f2_pivot_y;
  logic signed [24:0] f2_dx0;
  logic signed [24:0] f2_dy0;
  logic [22:0]        f2_width;
  logic [22:0]        f2_height;
  logic [15:0]        f2_u_start;
  logic [15:0]        f2_v_start;
  logic [15:0]        f2_u_end;
  logic [15:0]        f2_v_end;
  logic              adv;
  logic [15:0]       cos_ang;
  logic [PW-1:0]     sin_prod;
  logic [PW-1:0]     cos_prod;
  logic signed [15:0] sin_q;
  logic signed [15:0] cos_q;

  assign adv      = !f2_valid || !q_full;
  assign in_ready = adv;
  assign cos_ang  = in_sprite.angle + 16'd16384;
  assign sin_prod = PW'(in_sprite.angle) * PW'(SINE_TABLE_ENTRIES);
  assign cos_prod = PW'(cos_ang) * PW'(SINE_TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= in_valid;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1          <= in_sprite;
      f1_sin_addr <= sin_prod[PW-1:16];
      f1_cos_addr <= cos_prod[PW-1:16];
      f2_pivot_x  <= f1.pivot_x;
      f2_pivot_y  <= f1.pivot_y;
      f2_dx0      <= 25'(f1.corner_x) - 25'(f1.pivot_x);
      f2_dy0      <= 25'(f1.corner_y) - 25'(f1.pivot_y);
      f2_width    <= f1.quad_width;
      f2_height   <= f1.quad_height;
      f2_u_start  <= f1.tex_u_start;
      f2_v_start  <= f1.tex_v_start;
      f2_u_end    <= f1.tex_u_end;
      f2_v_end    <= f1.tex_v_end;
    end
  end

  assign qent = {f2_pivot_x, f2_pivot_y, f2_dx0, f2_dy0, f2_width, f2_height,
                 sin_q, cos_q, f2_u_start, f2_v_start, f2_u_end, f2_v_end};
  assign qctl.push = f2_valid && !q_full;

  rsqv_sine_rom #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_rom (
    .clk     (clk),
    .en      (adv),
    .sin_addr(f1_sin_addr),
    .cos_addr(f1_cos_addr),
    .sin_q   (sin_q),
    .cos_q   (cos_q)
  );

endmodule

@@ rtl/rsqv_queue.sv @@
// Four-entry queue of classified sprites between front and back.
// Depends on rsqv_pkg.
module rsqv_queue (
  input  logic            clk,
  input  logic            rst,
  input  rsqv_pkg::qctl_t   qctl,
  input  rsqv_pkg::qent_t   wr_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output rsqv_pkg::qent_t   rd_data
);

  localparam int DEPTH = 4;
  localparam int PTRW  = $clog2(DEPTH);

  rsqv_pkg::qent_t mem [DEPTH];
  logic [PTRW-1:0] wptr;
  logic [PTRW-1:0] rptr;
  logic [PTRW:0]   count;

  assign full    = (count == (PTRW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (qctl.push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({qctl.push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (qctl.push) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

@@ rtl/rsqv_back.sv @@
// Back end: expands a sprite into four vertices, rotates, rounds and saturates.
// Depends on rsqv_pkg.
module rsqv_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  rsqv_pkg::qent_t   q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output rsqv_pkg::vert_t   vert
);

  localparam logic signed [30:0] POS_MAX = 31'sd8388607;
  localparam logic signed [30:0] POS_MIN = -31'sd8388608;

  logic            en;
  logic            load;
  logic            cur_valid;
  logic [1:0]      k;
  rsqv_pkg::qent_t cur;
  logic            right;
  logic            top;

  logic               b1_valid;
  logic signed [25:0] b1_dx;
  logic signed [25:0] b1_dy;
  logic signed [15:0] b1_s;
  logic signed [15:0] b1_c;
  logic signed [23:0] b1_px;
  logic signed [23:0] b1_py;
  logic [15:0]        b1_u;
  logic [15:0]        b1_v;
  logic               b1_last;

  logic               b2_valid;
  logic signed [41:0] b2_cdx;
  logic signed [41:0] b2_sdy;
  logic signed [41:0] b2_sdx;
  logic signed [41:0] b2_cdy;
  logic signed [23:0] b2_px;
  logic signed [23:0] b2_py;
  logic [15:0]        b2_u;
  logic [15:0]        b2_v;
  logic               b2_last;

  logic signed [43:0] sum_x;
  logic signed [43:0] sum_y;
  logic signed [30:0] tot_x;
  logic signed [30:0] tot_y;

  assign en    = !out_valid || out_ready;
  assign load  = en && (!cur_valid || k == 2'd3);
  assign q_pop = load && !q_empty;
  assign right = (k == 2'd1) || (k == 2'd2);
  assign top   = k[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k         <= '0;
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_valid  <= cur_valid;
      b2_valid  <= b1_valid;
      out_valid <= b2_valid;
      if (load) begin
        cur_valid <= !q_empty;
        k         <= '0;
      end else begin
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_comb begin
    sum_x = 44'(b2_cdx) - 44'(b2_sdy) + 44'sd8192;
    sum_y = 44'(b2_sdx) + 44'(b2_cdy) + 44'sd8192;
    tot_x = 31'(b2_px) + 31'($signed(sum_x[43:14]));
    tot_y = 31'(b2_py) + 31'($signed(sum_y[43:14]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_dx   <= 26'(cur.dx0) + (right ? 26'(cur.quad_width) : 26'sd0);
      b1_dy   <= 26'(cur.dy0) + (top ? 26'(cur.quad_height) : 26'sd0);
      b1_s    <= cur.sin_v;
      b1_c    <= cur.cos_v;
      b1_px   <= cur.pivot_x;
      b1_py   <= cur.pivot_y;
      b1_u    <= right ? cur.tex_u_end : cur.tex_u_start;
      b1_v    <= top ? cur.tex_v_end : cur.tex_v_start;
      b1_last <= (k == 2'd3);

      b2_cdx  <= 42'(b1_c) * 42'(b1_dx);
      b2_sdy  <= 42'(b1_s) * 42'(b1_dy);
      b2_sdx  <= 42'(b1_s) * 42'(b1_dx);
      b2_cdy  <= 42'(b1_c) * 42'(b1_dy);
      b2_px   <= b1_px;
      b2_py   <= b1_py;
      b2_u    <= b1_u;
      b2_v    <= b1_v;
      b2_last <= b1_last;

      if (tot_x > POS_MAX) begin
        vert.pos_x <= POS_MAX[23:0];
      end else if (tot_x < POS_MIN) begin
        vert.pos_x <= POS_MIN[23:0];
      end else begin
        vert.pos_x <= tot_x[23:0];
      end
      if (tot_y > POS_MAX) begin
        vert.pos_y <= POS_MAX[23:0];
      end else if (tot_y < POS_MIN) begin
        vert.pos_y <= POS_MIN[23:0];
      end else begin
        vert.pos_y <= tot_y[23:0];
      end
      vert.tex_u       <= b2_u;
      vert.tex_v       <= b2_v;
      vert.last_vertex <= b2_last;
    end
  end

endmodule
